// ----- hdl/rc5_pkg.sv -----
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared types and constants for the RC5 infrared frame decoder.
// ----------------------------------------------------------------------------
package rc5_pkg;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned RC5_BITS    = 14;
  localparam int unsigned NBITS_W     = 4;
  localparam int unsigned START_POS   = 13;
  localparam int unsigned FIELD_POS   = 12;
  localparam int unsigned TOGGLE_POS  = 11;
  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [2:0] REG_FRAME_GAP_LIMIT = 3'd0;
  localparam logic [2:0] REG_MIN_PULSE       = 3'd1;
  localparam logic [2:0] REG_ONE_SLOT_LOW    = 3'd2;
  localparam logic [2:0] REG_ONE_SLOT_HIGH   = 3'd3;
  localparam logic [2:0] REG_TWO_SLOT_LOW    = 3'd4;
  localparam logic [2:0] REG_TWO_SLOT_HIGH   = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] RST_FRAME_GAP_LIMIT = 16'd5000;
  localparam logic [CFG_W-1:0] RST_MIN_PULSE       = 16'd800;
  localparam logic [CFG_W-1:0] RST_ONE_SLOT_LOW    = 16'd1400;
  localparam logic [CFG_W-1:0] RST_ONE_SLOT_HIGH   = 16'd2600;
  localparam logic [CFG_W-1:0] RST_TWO_SLOT_LOW    = 16'd2900;
  localparam logic [CFG_W-1:0] RST_TWO_SLOT_HIGH   = 16'd4200;

  typedef struct packed {
    logic [15:0] interval;
    logic        line_level;
  } item_t;

  typedef struct packed {
    logic       frame_valid;
    logic       start_flag;
    logic       field_flag;
    logic       toggle_flag;
    logic [4:0] device_address;
    logic [6:0] command_code;
  } result_t;

  typedef enum logic [1:0] {
    OP_APPEND1,
    OP_APPEND2,
    OP_FRAME_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     halfbit;
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SKIP,
    B_DECODE
  } back_state_t;

endpackage

// ----- hdl/rc5_front.sv -----
// ----------------------------------------------------------------------------
// rc5_front
// Timing registers on the APB port and classification of edge intervals.
// ----------------------------------------------------------------------------
module rc5_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rc5_pkg::PADDR_W-1:0]   paddr,
  input  logic [rc5_pkg::PDATA_W-1:0]   pwdata,
  output logic [rc5_pkg::PDATA_W-1:0]   prdata,
  input  logic                          accept,
  input  rc5_pkg::item_t                item,
  output logic                          push,
  output rc5_pkg::op_t                  op
);

  logic [rc5_pkg::CFG_W-1:0] frame_gap_limit;
  logic [rc5_pkg::CFG_W-1:0] min_pulse;
  logic [rc5_pkg::CFG_W-1:0] one_slot_low;
  logic [rc5_pkg::CFG_W-1:0] one_slot_high;
  logic [rc5_pkg::CFG_W-1:0] two_slot_low;
  logic [rc5_pkg::CFG_W-1:0] two_slot_high;
  logic [rc5_pkg::CFG_W-1:0] rd_value;
  logic [2:0]                reg_idx;
  logic                      wr_en;
  logic                      in_one;
  logic                      in_two;
  logic                      is_gap;
  logic                      is_glitch;

  assign reg_idx = paddr[rc5_pkg::PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_gap_limit <= rc5_pkg::RST_FRAME_GAP_LIMIT;
      min_pulse       <= rc5_pkg::RST_MIN_PULSE;
      one_slot_low    <= rc5_pkg::RST_ONE_SLOT_LOW;
      one_slot_high   <= rc5_pkg::RST_ONE_SLOT_HIGH;
      two_slot_low    <= rc5_pkg::RST_TWO_SLOT_LOW;
      two_slot_high   <= rc5_pkg::RST_TWO_SLOT_HIGH;
    end else if (wr_en) begin
      case (reg_idx)
        rc5_pkg::REG_FRAME_GAP_LIMIT: frame_gap_limit <= pwdata[rc5_pkg::CFG_W-1:0];
        rc5_pkg::REG_MIN_PULSE:       min_pulse       <= pwdata[rc5_pkg::CFG_W-1:0];
        rc5_pkg::REG_ONE_SLOT_LOW:    one_slot_low    <= pwdata[rc5_pkg::CFG_W-1:0];
        rc5_pkg::REG_ONE_SLOT_HIGH:   one_slot_high   <= pwdata[rc5_pkg::CFG_W-1:0];
        rc5_pkg::REG_TWO_SLOT_LOW:    two_slot_low    <= pwdata[rc5_pkg::CFG_W-1:0];
        rc5_pkg::REG_TWO_SLOT_HIGH:   two_slot_high   <= pwdata[rc5_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rc5_pkg::REG_FRAME_GAP_LIMIT: rd_value = frame_gap_limit;
      rc5_pkg::REG_MIN_PULSE:       rd_value = min_pulse;
      rc5_pkg::REG_ONE_SLOT_LOW:    rd_value = one_slot_low;
      rc5_pkg::REG_ONE_SLOT_HIGH:   rd_value = one_slot_high;
      rc5_pkg::REG_TWO_SLOT_LOW:    rd_value = two_slot_low;
      rc5_pkg::REG_TWO_SLOT_HIGH:   rd_value = two_slot_high;
      default:                      rd_value = '0;
    endcase
  end

  assign prdata = {{(rc5_pkg::PDATA_W - rc5_pkg::CFG_W){1'b0}}, rd_value};

  assign is_gap    = item.interval > frame_gap_limit;
  assign is_glitch = item.interval < min_pulse;
  assign in_one    = (item.interval >= one_slot_low) && (item.interval <= one_slot_high);
  assign in_two    = (item.interval >= two_slot_low) && (item.interval <= two_slot_high);

  // the stored half-bit is the inverse of the line level
  always_comb begin
    op.halfbit = ~item.line_level;
    op.kind    = rc5_pkg::OP_APPEND1;
    push       = 1'b0;
    if (is_gap) begin
      op.kind = rc5_pkg::OP_FRAME_END;
      push    = accept;
    end else if (!is_glitch && in_one) begin
      op.kind = rc5_pkg::OP_APPEND1;
      push    = accept;
    end else if (!is_glitch && in_two) begin
      op.kind = rc5_pkg::OP_APPEND2;
      push    = accept;
    end
  end

endmodule

// ----- hdl/rc5_fifo.sv -----
// ----------------------------------------------------------------------------
// rc5_fifo
// Short request queue between the classifier and the frame engine.
// ----------------------------------------------------------------------------
module rc5_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  rc5_pkg::op_t push_op,
  input  logic         pop,
  output rc5_pkg::op_t head_op,
  output logic         empty,
  output logic         full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rc5_pkg::op_t     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/rc5_back.sv -----
// ----------------------------------------------------------------------------
// rc5_back
// Half-bit store and serial Manchester pair decoder run at frame end.
// ----------------------------------------------------------------------------
module rc5_back #(
  parameter int unsigned MAX_HALF_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  rc5_pkg::op_t     head_op,
  output logic             pop,
  output logic             done,
  output rc5_pkg::result_t result
);

  localparam int unsigned CNT_W = $clog2(MAX_HALF_BITS + 1);

  rc5_pkg::back_state_t          state;
  rc5_pkg::back_state_t          state_next;
  logic [MAX_HALF_BITS-1:0]      store;
  logic [MAX_HALF_BITS-1:0]      work;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic [CNT_W-1:0]              count_p1;
  logic [CNT_W:0]                count_p2;
  logic [CNT_W-1:0]              rem;
  logic [rc5_pkg::NBITS_W-1:0]   nbits;
  logic [rc5_pkg::RC5_BITS-1:0]  word;
  logic                          wr_first;
  logic                          wr_second;
  logic                          load;
  logic                          skip_pair;
  logic                          take_pair;
  logic                          take_pad;
  logic                          finish_ok;
  logic                          finish_bad;
  logic                          pair_equal;
  logic                          decode_end;

  assign pair_equal = (work[0] == work[1]);
  assign decode_end = (rem == '0) || (nbits == rc5_pkg::NBITS_W'(rc5_pkg::RC5_BITS));
  assign count_p1   = count + 1'b1;
  assign count_p2   = {1'b0, count} + (CNT_W + 1)'(2);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rc5_pkg::B_IDLE: begin
        if (!empty && head_op.kind == rc5_pkg::OP_FRAME_END) begin
          state_next = rc5_pkg::B_SKIP;
        end
      end
      rc5_pkg::B_SKIP: begin
        if (!(rem > CNT_W'(1) && pair_equal)) begin
          state_next = rc5_pkg::B_DECODE;
        end
      end
      rc5_pkg::B_DECODE: begin
        if (decode_end) begin
          state_next = rc5_pkg::B_IDLE;
        end else if (rem != CNT_W'(1) && pair_equal) begin
          state_next = rc5_pkg::B_IDLE;
        end
      end
      default: state_next = rc5_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop        = 1'b0;
    wr_first   = 1'b0;
    wr_second  = 1'b0;
    load       = 1'b0;
    skip_pair  = 1'b0;
    take_pair  = 1'b0;
    take_pad   = 1'b0;
    finish_ok  = 1'b0;
    finish_bad = 1'b0;
    case (state)
      rc5_pkg::B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head_op.kind)
            rc5_pkg::OP_APPEND1: wr_first = 1'b1;
            rc5_pkg::OP_APPEND2: begin
              wr_first  = 1'b1;
              wr_second = 1'b1;
            end
            rc5_pkg::OP_FRAME_END: load = 1'b1;
            default: ;
          endcase
        end
      end
      rc5_pkg::B_SKIP: begin
        skip_pair = (rem > CNT_W'(1)) && pair_equal;
      end
      rc5_pkg::B_DECODE: begin
        if (decode_end) begin
          finish_ok = 1'b1;
        end else if (rem == CNT_W'(1)) begin
          // odd tail: padded with the complement of the last half-bit
          take_pad = 1'b1;
        end else if (!pair_equal) begin
          take_pair = 1'b1;
        end else begin
          finish_bad = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_next = count;
    if (load) begin
      count_next = '0;
    end else if (wr_second) begin
      if (count_p2 <= (CNT_W + 1)'(MAX_HALF_BITS)) begin
        count_next = count_p2[CNT_W-1:0];
      end else if (count < CNT_W'(MAX_HALF_BITS)) begin
        count_next = count_p1;
      end
    end else if (wr_first) begin
      if (count < CNT_W'(MAX_HALF_BITS)) begin
        count_next = count_p1;
      end
    end
  end

  // store entries past the cap are simply never addressed
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_HALF_BITS; i++) begin
      if (wr_first && count == CNT_W'(i)) begin
        store[i] <= head_op.halfbit;
      end
      if (wr_second && count_p1 == CNT_W'(i)) begin
        store[i] <= head_op.halfbit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= store;
    end else if (skip_pair || take_pair) begin
      work <= {2'b00, work[MAX_HALF_BITS-1:2]};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= count;
      nbits <= '0;
      word  <= '0;
    end else if (skip_pair || take_pair) begin
      rem <= rem - CNT_W'(2);
      if (take_pair) begin
        nbits <= nbits + 1'b1;
      end
    end else if (take_pad) begin
      rem   <= '0;
      nbits <= nbits + 1'b1;
    end
    if (take_pair || take_pad) begin
      for (int j = 0; j < rc5_pkg::RC5_BITS; j++) begin
        if (nbits == rc5_pkg::NBITS_W'(rc5_pkg::RC5_BITS - 1 - j)) begin
          word[j] <= work[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish_ok) begin
      result.frame_valid    <= 1'b1;
      result.start_flag     <= word[rc5_pkg::START_POS];
      result.field_flag     <= word[rc5_pkg::FIELD_POS];
      result.toggle_flag    <= word[rc5_pkg::TOGGLE_POS];
      result.device_address <= word[rc5_pkg::TOGGLE_POS-1:6];
      result.command_code   <= {~word[rc5_pkg::FIELD_POS], word[5:0]};
    end else if (finish_bad) begin
      result <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rc5_pkg::B_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish_ok || finish_bad;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_decode: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == rc5_pkg::B_DECODE)
    else $error("result strobe without a decode step");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_HALF_BITS))
    else $error("half-bit count beyond store size");

  a_skip_flow: assert property (@(posedge clk) disable iff (rst)
    state == rc5_pkg::B_SKIP |=> state == rc5_pkg::B_SKIP || state == rc5_pkg::B_DECODE)
    else $error("skip phase left without decoding");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.frame_valid |-> result.start_flag == 1'b0 &&
      result.device_address == '0 && result.command_code == '0)
    else $error("invalid frame carries nonzero fields");
`endif

endmodule

// ----- hdl/rc5_ir_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// rc5_ir_frame_decoder
// RC5 infrared decoder: IR edge intervals in, decoded frames out.
// ----------------------------------------------------------------------------
// frame end: an edge that ends a frame passes through the queue; the engine then loads
//   the store in idle, steps pairs in the skip and decode states and registers done
// throughput: edges are taken one per cycle into a 4-entry queue while it is not full;
//   the decode engine retires one append per cycle and stops popping during a frame end
// reset: timing registers return to defaults, queue and half-bit count clear;
//   store contents stay undefined and are never read before being written
module rc5_ir_frame_decoder #(
  parameter int unsigned MAX_HALF_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rc5_pkg::PADDR_W-1:0]   paddr,
  input  logic [rc5_pkg::PDATA_W-1:0]   pwdata,
  output logic [rc5_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  input  rc5_pkg::item_t                item,
  output logic                          busy,
  output logic                          done,
  output rc5_pkg::result_t              result
);

  logic         accept;
  logic         push;
  logic         pop;
  logic         empty;
  logic         full;
  rc5_pkg::op_t push_op;
  rc5_pkg::op_t head_op;

  assign pready = 1'b1;
  assign busy   = full;
  assign accept = start && !busy;

  rc5_front u_front (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .accept  (accept),
    .item    (item),
    .push    (push),
    .op      (push_op)
  );

  rc5_fifo #(
    .DEPTH (rc5_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (empty),
    .full    (full)
  );

  rc5_back #(
    .MAX_HALF_BITS (MAX_HALF_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .head_op (head_op),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule
